### rtl/gmsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmsp_pkg
// Shared types and constants of the grid maze shortest path block.
// ----------------------------------------------------------------------------
package gmsp_pkg;

	localparam int COORD_W      = 3;
	localparam int MARK_W       = 7;
	localparam int CFG_W        = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int DEF_MAX_ROWS = 8;
	localparam int DEF_MAX_COLS = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd5;

	localparam logic [CFG_W-1:0]   RST_ROWS      = 4'd6;
	localparam logic [CFG_W-1:0]   RST_COLS      = 4'd6;
	localparam logic [COORD_W-1:0] RST_START_ROW = 3'd5;
	localparam logic [COORD_W-1:0] RST_START_COL = 3'd5;
	localparam logic [COORD_W-1:0] RST_GOAL_ROW  = 3'd0;
	localparam logic [COORD_W-1:0] RST_GOAL_COL  = 3'd0;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} cell_t;

endpackage
`default_nettype wire

### rtl/grid_maze_shortest_path.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_maze_shortest_path
// Depth-first maze search with distance relaxation over RAM-held state.
// ----------------------------------------------------------------------------
// A load transaction (tuser 0) writes one wall bit. A solve transaction
// (tuser 1) runs the setup states ST_START, ST_CHK_G and ST_CHK_E, then
// skips a direction that leaves the grid in ST_ISSUE, takes every neighbour
// inside it through ST_ISSUE and ST_CHECK (mark RAM read, then decide), pops
// through ST_POPW (stack RAM read of the new top), and copies the stack to
// the best-path RAM each time the goal is reached; the run is bounded by the
// search itself. The path then leaves one result at a time, each held until
// m_tready is high, from the best-path RAM read port, start cell first, tlast
// on the goal. No path, a start or goal outside the grid, or a wall at start
// or goal, gives one result with tuser (found) clear. Distance marks carry a
// valid bit per cell, cleared at the start of every solve.
module grid_maze_shortest_path #(
	parameter int MAX_ROWS = gmsp_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gmsp_pkg::DEF_MAX_COLS
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // cell_row[2:0], cell_col[5:3], cell_wall[6], zero[7]
	input  wire        s_tuser,   // opcode
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // step_row[2:0], step_col[5:3], zero[7:6]
	output logic       m_tuser,   // found
	output logic       m_tlast,   // last_step
	input  wire        cfg_we,
	input  wire  [gmsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [gmsp_pkg::CFG_W-1:0]     cfg_data
);

	localparam int RB     = $clog2(MAX_ROWS);
	localparam int CB     = $clog2(MAX_COLS);
	localparam int AW     = RB + CB;
	localparam int ADEPTH = 1 << AW;
	localparam int NCELLS = MAX_ROWS * MAX_COLS;
	localparam int SW     = $clog2(NCELLS);
	localparam int DW     = $clog2(NCELLS + 1);
	localparam int MW     = gmsp_pkg::MARK_W;
	localparam int QW     = gmsp_pkg::COORD_W;
	localparam int FW     = gmsp_pkg::CFG_W;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_START = 13'b0000000000010,
		ST_CHK_G = 13'b0000000000100,
		ST_CHK_E = 13'b0000000001000,
		ST_ISSUE = 13'b0000000010000,
		ST_CHECK = 13'b0000000100000,
		ST_POPW  = 13'b0000001000000,
		ST_COPY  = 13'b0000010000000,
		ST_EMIT  = 13'b0000100000000,
		ST_EMITR = 13'b0001000000000,
		ST_OUTW  = 13'b0010000000000,
		ST_SPARE = 13'b0100000000000,
		ST_HOLD  = 13'b1000000000000
	} state_t;

	function automatic logic [AW-1:0] cell_addr(gmsp_pkg::cell_t c);
		return {c.row[RB-1:0], c.col[CB-1:0]};
	endfunction

	state_t                 state_q;
	logic [FW-1:0]          rows_q, cols_q;
	gmsp_pkg::cell_t        start_q, goal_q;
	logic [FW-1:0]          rows_eff, cols_eff;

	gmsp_pkg::cell_t        top_q, nb_q, nb_c;
	gmsp_pkg::dir_t         dir_q;
	logic                   nb_ok;
	logic [DW-1:0]          depth_q, cp_q, em_q, len_q;
	logic                   cp_vld_s1;
	logic [SW-1:0]          cp_idx_s1;

	logic [ADEPTH-1:0]      wvld_q, dvld_q;
	logic [AW-1:0]          wraddr_s1;

	logic                   out_found_q, out_last_q;
	gmsp_pkg::cell_t        out_cell_q;

	// RAM ports
	logic                   wall_we, wall_wdata, wall_rdata, wall_rd;
	logic [AW-1:0]          wall_waddr, wall_raddr;
	logic                   dist_we;
	logic [AW-1:0]          dist_waddr;
	logic [MW-1:0]          dist_wdata, dist_rdata;
	logic                   stk_we;
	logic [SW-1:0]          stk_waddr, stk_raddr;
	gmsp_pkg::cell_t        stk_wdata, stk_rdata;
	logic                   best_we;
	logic [SW-1:0]          best_waddr;
	gmsp_pkg::cell_t        best_wdata, best_rdata;

	logic                   in_acc, load_ok;
	gmsp_pkg::cell_t        in_cell;
	logic [MW:0]            here_p1;
	logic                   enter, full, at_goal, copy_busy, copy_done;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_cell  = '{row: s_tdata[2:0], col: s_tdata[5:3]};
	assign load_ok  = (32'(in_cell.row) < MAX_ROWS) && (32'(in_cell.col) < MAX_COLS);

	always_comb begin
		if (rows_q == '0)                rows_eff = FW'(1);
		else if (32'(rows_q) > MAX_ROWS) rows_eff = FW'(MAX_ROWS);
		else                             rows_eff = rows_q;
		if (cols_q == '0)                cols_eff = FW'(1);
		else if (32'(cols_q) > MAX_COLS) cols_eff = FW'(MAX_COLS);
		else                             cols_eff = cols_q;
	end

	// neighbour of the top cell in the current direction
	always_comb begin
		nb_c  = top_q;
		nb_ok = 1'b0;
		case (dir_q)
			gmsp_pkg::DIR_UP: begin
				nb_ok      = (top_q.row != '0);
				nb_c.row   = top_q.row - QW'(1);
			end
			gmsp_pkg::DIR_RIGHT: begin
				nb_ok      = (FW'(top_q.col) + FW'(1) < cols_eff);
				nb_c.col   = top_q.col + QW'(1);
			end
			gmsp_pkg::DIR_DOWN: begin
				nb_ok      = (FW'(top_q.row) + FW'(1) < rows_eff);
				nb_c.row   = top_q.row + QW'(1);
			end
			default: begin
				nb_ok      = (top_q.col != '0);
				nb_c.col   = top_q.col - QW'(1);
			end
		endcase
	end

	assign wall_rd = wvld_q[wraddr_s1] & wall_rdata;
	assign here_p1 = (MW+1)'(depth_q) + (MW+1)'(1);
	assign enter   = !wall_rd && (!dvld_q[cell_addr(nb_q)] || (here_p1 < {1'b0, dist_rdata}));
	assign full    = (depth_q >= DW'(NCELLS));
	assign at_goal = (nb_q == goal_q);
	assign copy_busy = (cp_q < depth_q);
	assign copy_done = !copy_busy && !cp_vld_s1;

	always_comb begin
		wall_we    = in_acc && (s_tuser == gmsp_pkg::OP_LOAD) && load_ok;
		wall_waddr = cell_addr(in_cell);
		wall_wdata = s_tdata[6];
		unique case (state_q)
			ST_START: wall_raddr = cell_addr(start_q);
			ST_CHK_G: wall_raddr = cell_addr(goal_q);
			default:  wall_raddr = cell_addr(nb_c);
		endcase

		dist_we    = 1'b0;
		dist_waddr = cell_addr(nb_q);
		dist_wdata = MW'(here_p1);
		stk_we     = 1'b0;
		stk_waddr  = depth_q[SW-1:0];
		stk_wdata  = nb_q;
		best_we    = 1'b0;
		best_waddr = depth_q[SW-1:0];
		best_wdata = goal_q;

		if (state_q == ST_CHK_E && !wall_rd) begin
			if (start_q == goal_q) begin
				best_we    = 1'b1;
				best_waddr = '0;
				best_wdata = start_q;
			end else begin
				dist_we    = 1'b1;
				dist_waddr = cell_addr(start_q);
				dist_wdata = MW'(1);
				stk_we     = 1'b1;
				stk_waddr  = '0;
				stk_wdata  = start_q;
			end
		end
		if (state_q == ST_CHECK && enter && !full) begin
			dist_we = 1'b1;
			stk_we  = !at_goal;
		end
		if (state_q == ST_COPY) begin
			if (cp_vld_s1) begin
				best_we    = 1'b1;
				best_waddr = cp_idx_s1;
				best_wdata = stk_rdata;
			end else if (copy_done) begin
				best_we    = 1'b1;
			end
		end

		stk_raddr = (state_q == ST_COPY) ? cp_q[SW-1:0] : SW'(depth_q - DW'(2));
	end

	gmsp_ram #(.WIDTH(1), .DEPTH(ADEPTH)) u_wall (
		.clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
		.raddr(wall_raddr), .rdata(wall_rdata)
	);

	gmsp_ram #(.WIDTH(MW), .DEPTH(ADEPTH)) u_dist (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(cell_addr(nb_c)), .rdata(dist_rdata)
	);

	gmsp_ram #(.WIDTH(2*QW), .DEPTH(NCELLS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	gmsp_ram #(.WIDTH(2*QW), .DEPTH(NCELLS)) u_best (
		.clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
		.raddr(em_q[SW-1:0]), .rdata(best_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= gmsp_pkg::RST_ROWS;
			cols_q  <= gmsp_pkg::RST_COLS;
			start_q <= '{row: gmsp_pkg::RST_START_ROW, col: gmsp_pkg::RST_START_COL};
			goal_q  <= '{row: gmsp_pkg::RST_GOAL_ROW, col: gmsp_pkg::RST_GOAL_COL};
		end else if (cfg_we) begin
			unique case (cfg_index)
				gmsp_pkg::REG_ROWS:      rows_q      <= cfg_data;
				gmsp_pkg::REG_COLS:      cols_q      <= cfg_data;
				gmsp_pkg::REG_START_ROW: start_q.row <= cfg_data[QW-1:0];
				gmsp_pkg::REG_START_COL: start_q.col <= cfg_data[QW-1:0];
				gmsp_pkg::REG_GOAL_ROW:  goal_q.row  <= cfg_data[QW-1:0];
				gmsp_pkg::REG_GOAL_COL:  goal_q.col  <= cfg_data[QW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wraddr_s1 <= wall_raddr;
		cp_idx_s1 <= cp_q[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wvld_q      <= '0;
			dvld_q      <= '0;
			depth_q     <= '0;
			len_q       <= '0;
			cp_q        <= '0;
			cp_vld_s1   <= 1'b0;
			em_q        <= '0;
			dir_q       <= gmsp_pkg::DIR_UP;
			top_q       <= '0;
			nb_q        <= '0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_cell_q  <= '0;
		end else begin
			if (wall_we) wvld_q[wall_waddr] <= 1'b1;
			if (dist_we) dvld_q[dist_waddr] <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == gmsp_pkg::OP_SOLVE) state_q <= ST_START;
				end
				ST_START: begin
					dvld_q  <= '0;
					depth_q <= '0;
					len_q   <= '0;
					em_q    <= '0;
					if (FW'(start_q.row) >= rows_eff || FW'(start_q.col) >= cols_eff ||
					    FW'(goal_q.row) >= rows_eff || FW'(goal_q.col) >= cols_eff) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CHK_G;
					end
				end
				ST_CHK_G: begin
					state_q <= wall_rd ? ST_EMIT : ST_CHK_E;
				end
				ST_CHK_E: begin
					if (wall_rd) begin
						state_q <= ST_EMIT;
					end else if (start_q == goal_q) begin
						len_q   <= DW'(1);
						state_q <= ST_EMIT;
					end else begin
						depth_q <= DW'(1);
						top_q   <= start_q;
						dir_q   <= gmsp_pkg::DIR_UP;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					nb_q <= nb_c;
					if (nb_ok) begin
						state_q <= ST_CHECK;
					end else if (dir_q == gmsp_pkg::DIR_LEFT) begin
						depth_q <= depth_q - DW'(1);
						state_q <= (depth_q == DW'(1)) ? ST_EMIT : ST_POPW;
					end else begin
						dir_q <= gmsp_pkg::dir_t'(dir_q + 2'd1);
					end
				end
				ST_CHECK: begin
					if ((enter && full) || (!enter && dir_q == gmsp_pkg::DIR_LEFT)) begin
						depth_q <= depth_q - DW'(1);
						state_q <= (depth_q == DW'(1)) ? ST_EMIT : ST_POPW;
					end else if (!enter) begin
						dir_q   <= gmsp_pkg::dir_t'(dir_q + 2'd1);
						state_q <= ST_ISSUE;
					end else if (at_goal) begin
						cp_q      <= '0;
						cp_vld_s1 <= 1'b0;
						state_q   <= ST_COPY;
					end else begin
						depth_q <= depth_q + DW'(1);
						top_q   <= nb_q;
						dir_q   <= gmsp_pkg::DIR_UP;
						state_q <= ST_ISSUE;
					end
				end
				ST_POPW: begin
					top_q   <= stk_rdata;
					dir_q   <= gmsp_pkg::DIR_UP;
					state_q <= ST_ISSUE;
				end
				ST_COPY: begin
					// stream stack entries into the best path, goal cell last
					cp_vld_s1 <= copy_busy;
					if (copy_busy) cp_q <= cp_q + DW'(1);
					if (copy_done) begin
						len_q   <= depth_q + DW'(1);
						dir_q   <= gmsp_pkg::DIR_UP;
						state_q <= ST_ISSUE;
					end
				end
				ST_EMIT: begin
					if (len_q == '0) begin
						out_found_q <= 1'b0;
						out_cell_q  <= '0;
						out_last_q  <= 1'b1;
						state_q     <= ST_OUTW;
					end else begin
						state_q <= ST_EMITR;
					end
				end
				ST_EMITR: begin
					out_found_q <= 1'b1;
					out_cell_q  <= best_rdata;
					out_last_q  <= (em_q + DW'(1) == len_q);
					state_q     <= ST_OUTW;
				end
				ST_OUTW: begin
					if (m_tready) begin
						em_q    <= em_q + DW'(1);
						state_q <= out_last_q ? ST_IDLE : ST_EMIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_OUTW);
	assign m_tdata  = {2'b00, out_cell_q.col, out_cell_q.row};
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(NCELLS)) else $error("stack depth beyond grid size");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken while a result is pending");
	a_check_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (depth_q != '0)) else $error("neighbour check on empty stack");
	a_nopath_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast) else $error("no-path result without tlast");

endmodule
`default_nettype wire

### rtl/gmsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmsp_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gmsp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### sim/maze_path_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_path_checker
// Watches the item and path streams and the register port, predicts every
// path step by its own depth-first search, and compares it with the block.
// ----------------------------------------------------------------------------
module maze_path_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire  [7:0] s_tdata,
	input  wire        s_tuser,
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire  [7:0] m_tdata,
	input  wire        m_tuser,
	input  wire        m_tlast,
	input  wire        cfg_we,
	input  wire  [gmsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [gmsp_pkg::CFG_W-1:0]     cfg_data,
	output int         fail_count,
	output int         steps_pending,
	output int         steps_seen
);

	typedef struct packed {
		logic       found;
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
	} step_t;

	step_t      path_q[$];
	logic [3:0] grid_rows, grid_cols;
	logic [2:0] src_row, src_col, dst_row, dst_col;
	logic       wall[64];

	assign steps_pending = path_q.size();

	function automatic bit may_enter(int here, int nb, ref int mark[64]);
		return mark[nb] == 0 || mark[here] + 1 < mark[nb];
	endfunction

	// append one expected step at the tail of the queue
	function automatic void queue_step(step_t st);
		path_q.insert(path_q.size(), st);
	endfunction

	task automatic solve_maze();
		int rows, cols, s, g, depth, top, nb, r, c, best_len;
		int mark[64];
		int stk[64];
		int best[64];
		step_t st;
		rows = (grid_rows == 0) ? 1 : (grid_rows > 8) ? 8 : grid_rows;
		cols = (grid_cols == 0) ? 1 : (grid_cols > 8) ? 8 : grid_cols;
		best_len = 0;
		s = src_row * 8 + src_col;
		g = dst_row * 8 + dst_col;
		if (src_row < rows && src_col < cols && dst_row < rows && dst_col < cols
				&& !wall[s] && !wall[g]) begin
			for (int i = 0; i < 64; i++) mark[i] = wall[i] ? 1 : 0;
			if (s == g) begin
				best[0] = s;
				best_len = 1;
			end else begin
				stk[0] = s;
				depth = 1;
				mark[s] = 1;
				while (depth > 0) begin
					top = stk[depth-1];
					r = top / 8;
					c = top % 8;
					nb = 64;
					if (r >= 1 && may_enter(top, top - 8, mark)) nb = top - 8;
					else if (c + 1 < cols && may_enter(top, top + 1, mark)) nb = top + 1;
					else if (r + 1 < rows && may_enter(top, top + 8, mark)) nb = top + 8;
					else if (c >= 1 && may_enter(top, top - 1, mark)) nb = top - 1;
					if (nb >= 64 || depth >= 64) begin
						depth--;
						continue;
					end
					mark[nb] = (mark[top] + 1) & 8'h7f;
					if (nb == g) begin
						for (int i = 0; i < depth; i++) best[i] = stk[i];
						best[depth] = g;
						best_len = depth + 1;
						continue;
					end
					stk[depth] = nb;
					depth++;
				end
			end
		end
		if (best_len == 0) begin
			st = '{1'b0, 3'd0, 3'd0, 1'b1};
			queue_step(st);
		end else begin
			for (int i = 0; i < best_len; i++) begin
				st = '{1'b1, best[i][5:3], best[i][2:0], i + 1 == best_len};
				queue_step(st);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows <= gmsp_pkg::RST_ROWS;
			grid_cols <= gmsp_pkg::RST_COLS;
			src_row <= gmsp_pkg::RST_START_ROW;
			src_col <= gmsp_pkg::RST_START_COL;
			dst_row <= gmsp_pkg::RST_GOAL_ROW;
			dst_col <= gmsp_pkg::RST_GOAL_COL;
			for (int i = 0; i < 64; i++) wall[i] = 1'b0;
			path_q.delete();
			fail_count <= 0;
			steps_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gmsp_pkg::REG_ROWS:      grid_rows <= cfg_data;
					gmsp_pkg::REG_COLS:      grid_cols <= cfg_data;
					gmsp_pkg::REG_START_ROW: src_row <= cfg_data[2:0];
					gmsp_pkg::REG_START_COL: src_col <= cfg_data[2:0];
					gmsp_pkg::REG_GOAL_ROW:  dst_row <= cfg_data[2:0];
					gmsp_pkg::REG_GOAL_COL:  dst_col <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == gmsp_pkg::OP_LOAD) wall[s_tdata[2:0] * 8 + s_tdata[5:3]] = s_tdata[6];
				else solve_maze();
			end
			if (m_tvalid && m_tready) begin
				steps_seen <= steps_seen + 1;
				if (path_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected path step: found=%0d row=%0d col=%0d last=%0d",
							m_tuser, m_tdata[2:0], m_tdata[5:3], m_tlast);
					fail_count <= fail_count + 1;
				end else begin
					step_t e;
					e = path_q.pop_front();
					if (e.found !== m_tuser || e.row !== m_tdata[2:0]
							|| e.col !== m_tdata[5:3] || e.last !== m_tlast) begin
						if (fail_count < 10)
							$display("path step mismatch: expected f%0d r%0d c%0d l%0d, got f%0d r%0d c%0d l%0d",
								e.found, e.row, e.col, e.last,
								m_tuser, m_tdata[2:0], m_tdata[5:3], m_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### sim/tb_grid_maze_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_maze_shortest_path
// Loads random and shaped mazes, solves them under several grid settings and
// random stalls on both streams; the checker compares every path step.
// ----------------------------------------------------------------------------
module tb_grid_maze_shortest_path;

	localparam int CYCLE_LIMIT = 20000000;
	localparam logic [gmsp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [gmsp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic       clk, arst_n;
	logic       s_tvalid, s_tuser, m_tready, cfg_we;
	logic [7:0] s_tdata;
	logic [gmsp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gmsp_pkg::CFG_W-1:0]     cfg_data;
	wire        s_tready, m_tvalid, m_tuser, m_tlast;
	wire  [7:0] m_tdata;
	int         fail_count, steps_pending, steps_seen, cycles;

	grid_maze_shortest_path dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	maze_path_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .steps_pending(steps_pending), .steps_seen(steps_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// random stalls on the path stream, with quiet stretches
	initial begin : sink
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// tvalid stays high after a transaction; the next item drops it before a gap, and idle_input drops it
	task automatic send_item(input logic op, input logic [2:0] r, input logic [2:0] c,
			input logic w, input bit quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, w, c, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic idle_input();
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		idle_input();
		@(posedge clk);
		while (steps_pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gmsp_pkg::CFG_IDX_W-1:0] idx,
			input logic [gmsp_pkg::CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_grid(input int rows, input int cols, input int sr, input int sc,
			input int gr, input int gc);
		drain();
		write_reg(gmsp_pkg::REG_ROWS, rows);
		write_reg(gmsp_pkg::REG_COLS, cols);
		write_reg(gmsp_pkg::REG_START_ROW, sr);
		write_reg(gmsp_pkg::REG_START_COL, sc);
		write_reg(gmsp_pkg::REG_GOAL_ROW, gr);
		write_reg(gmsp_pkg::REG_GOAL_COL, gc);
	endtask

	task automatic solve_once();
		send_item(gmsp_pkg::OP_SOLVE, $urandom, $urandom, $urandom, 1'b0);
	endtask

	initial begin : stim
		int rows, cols, sent, quiet;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = gmsp_pkg::OP_LOAD;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings on an open map
		solve_once();
		// wall at goal, then at start
		send_item(gmsp_pkg::OP_LOAD, 0, 0, 1'b1, 1'b0);
		solve_once();
		send_item(gmsp_pkg::OP_LOAD, 0, 0, 1'b0, 1'b0);
		send_item(gmsp_pkg::OP_LOAD, 5, 5, 1'b1, 1'b0);
		solve_once();
		send_item(gmsp_pkg::OP_LOAD, 5, 5, 1'b0, 1'b0);
		send_item(gmsp_pkg::OP_LOAD, 7, 7, 1'b1, 1'b0);
		send_item(gmsp_pkg::OP_LOAD, 7, 7, 1'b0, 1'b0);
		// start equals goal, then sizes zero and above range
		set_grid(1, 1, 0, 0, 0, 0);
		solve_once();
		set_grid(0, 15, 0, 0, 0, 7);
		solve_once();
		// goal in the far corner of the full grid, then goal outside the grid in use
		set_grid(8, 8, 0, 0, 7, 7);
		solve_once();
		set_grid(4, 4, 0, 0, 7, 7);
		solve_once();
		// blocked wall column with no gap
		set_grid(3, 3, 0, 0, 0, 2);
		for (int r = 0; r < 3; r++) send_item(gmsp_pkg::OP_LOAD, r, 1, 1'b1, 1'b0);
		solve_once();
		for (int r = 0; r < 3; r++) send_item(gmsp_pkg::OP_LOAD, r, 1, 1'b0, 1'b0);
		// unused register index
		drain();
		write_reg(REG_SPARE_LO, 4'hf);
		write_reg(REG_SPARE_HI, 4'h0);

		sent = 30;
		while (sent < 320) begin
			// mostly small grids, a few at full size
			rows = ($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 5);
			cols = ($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 5);
			if ($urandom_range(0, 9) == 0) rows = $urandom_range(0, 15);
			set_grid(rows, cols, $urandom_range(0, rows > 0 ? (rows > 8 ? 7 : rows - 1) : 0),
				$urandom_range(0, cols > 0 ? (cols > 8 ? 7 : cols - 1) : 0),
				$urandom_range(0, 7), $urandom_range(0, 7));
			quiet = $urandom_range(0, 3) == 0;
			for (int r = 0; r < 8; r++)
				for (int c = 0; c < 8; c++)
					if ($urandom_range(0, 2) == 0 || (r < rows && c < cols
							&& $urandom_range(0, 1) == 0)) begin
						send_item(gmsp_pkg::OP_LOAD, r, c, $urandom_range(0, 3) == 0, quiet);
						sent++;
					end
			for (int k = 0; k < 3; k++) begin
				solve_once();
				sent++;
			end
		end

		drain();
		if (fail_count == 0 && steps_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
